// ===== hw/rtl/mff_pkg.sv =====
// Package: constants, codes and types shared by the maze flood-fill router.
package mff_pkg;
  localparam int MazeSize = 16;
  localparam int Cells = MazeSize * MazeSize;
  localparam int CellW = $clog2(Cells);
  localparam int FrontierDepth = 256;
  localparam int FrontW = $clog2(FrontierDepth);
  localparam logic [15:0] Unreached = 16'hFFFF;
  localparam logic [15:0] Cap = Unreached - 16'd1;
  localparam logic [15:0] ResetDist = 16'd2000;
  localparam logic [15:0] GrowStep = 16'd5;

  localparam logic [1:0] WOpen = 2'd0;
  localparam logic [1:0] WPresent = 2'd1;
  localparam logic [1:0] WUnknown = 2'd2;

  typedef enum logic [1:0] {
    KIND_WALLS = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_FLOOD = 2'd2,
    KIND_STEP = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_DONE = 3'd0,
    ST_MOVED = 3'd1,
    ST_AT_TARGET = 3'd2,
    ST_NO_LOWER = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RESET_SWEEP, S_CLEAR, S_FL_INIT, S_FL_POP, S_FL_POP_WAIT,
    S_FL_CELL, S_FL_GROW, S_FL_NB_RD, S_FL_NB_WAIT, S_FL_NB_CMP, S_FL_SWAP,
    S_ST_RD, S_ST_WAIT, S_ST_CUR, S_ST_NB_WAIT, S_ST_NB_CMP, S_OUT_RD,
    S_OUT_WAIT, S_OUT
  } state_t;

  // Reset wall code of one cell: border walls present, rest unknown.
  function automatic logic [7:0] reset_walls(input logic [CellW-1:0] c);
    logic [CellW/2-1:0] x;
    logic [CellW/2-1:0] y;
    logic [1:0] n, e, s, w;
    x = c[CellW/2-1:0];
    y = c[CellW-1:CellW/2];
    n = (y == '0) ? WPresent : WUnknown;
    e = (x == '1) ? WPresent : WUnknown;
    s = (y == '1) ? WPresent : WUnknown;
    w = (x == '0) ? WPresent : WUnknown;
    return {w, s, e, n};
  endfunction

  // Saturating add, clamped at Cap; used to grow flood distances.
  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return (sum > {1'b0, Cap}) ? Cap : sum[15:0];
  endfunction
endpackage

// ===== hw/rtl/mff_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
module mff_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/maze_flood_fill_router_top.sv =====
// Top level: maze store, frontier queues and the sequencer of the router.
//
// Command-style block. A transaction is taken when start is high and busy is
// low; each gives exactly one result, shown on the out_ ports for one cycle
// with out_valid high, and the receiver cannot stall it. After reset the block
// sweeps the 256 cells to load the reset walls and distances, busy throughout.
// A wall write stores the walls and reads the result distance, a distance
// clear first writes every cell, and a descent step reads the cell, then the
// distance behind each open side (a blocked side is skipped), then the result
// distance. A flood pops each frontier entry and reads its cell, reads and
// compares each neighbour that it may pass, and copies each new wave into
// the current queue; its rate is set by the single read port of the distance
// memory, shared by every compare of the flood.
module maze_flood_fill_router_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_kind,
  input  logic [3:0]           in_cell_x,
  input  logic [3:0]           in_cell_y,
  input  logic [3:0]           in_target_x,
  input  logic [3:0]           in_target_y,
  input  logic [1:0]           in_north_wall,
  input  logic [1:0]           in_east_wall,
  input  logic [1:0]           in_south_wall,
  input  logic [1:0]           in_west_wall,
  input  logic                 in_unknown_open,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [3:0]           out_next_x,
  output logic [3:0]           out_next_y,
  output logic [15:0]          out_next_distance
);
  import mff_pkg::*;

  state_t state_r, state_nxt;

  // Latched command.
  kind_t           kind_r;
  logic [3:0]      cx_r, cy_r, tx_r, ty_r;
  logic            unk_r;
  logic [7:0]      wall_in_r;

  // Work registers.
  logic [CellW:0]  sweep_r, sweep_nxt;
  logic [FrontW:0] cnt_now_r, cnt_now_nxt;
  logic [FrontW:0] cnt_next_r, cnt_next_nxt;
  logic [FrontW:0] pos_r, pos_nxt;
  logic [CellW-1:0] cell_r, cell_nxt;
  logic [7:0]      walls_r, walls_nxt;
  logic [15:0]     dist_r, dist_nxt;
  logic [15:0]     len_r, len_nxt;
  logic [1:0]      side_r, side_nxt;
  logic            ovf_r, ovf_nxt;
  logic [2:0]      status_r, status_nxt;
  logic [3:0]      nx_r, nx_nxt, ny_r, ny_nxt;
  logic            copying_r, copying_nxt;

  // Memory ports.
  logic             wall_we, dist_we, fn_we, fx_we;
  logic [CellW-1:0] wall_wa, dist_wa, wall_ra, dist_ra;
  logic [7:0]       wall_wd, wall_rd;
  logic [15:0]      dist_wd, dist_rd;
  logic [FrontW-1:0] fn_wa, fn_ra, fx_wa, fx_ra;
  logic [CellW-1:0] fn_wd, fn_rd, fx_wd, fx_rd;

  mff_ram #(.Width(8), .Depth(Cells)) u_walls (
    .clk, .we(wall_we), .waddr(wall_wa), .wdata(wall_wd), .raddr(wall_ra), .rdata(wall_rd));
  mff_ram #(.Width(16), .Depth(Cells)) u_dist (
    .clk, .we(dist_we), .waddr(dist_wa), .wdata(dist_wd), .raddr(dist_ra), .rdata(dist_rd));
  mff_ram #(.Width(CellW), .Depth(FrontierDepth)) u_front_now (
    .clk, .we(fn_we), .waddr(fn_wa), .wdata(fn_wd), .raddr(fn_ra), .rdata(fn_rd));
  mff_ram #(.Width(CellW), .Depth(FrontierDepth)) u_front_next (
    .clk, .we(fx_we), .waddr(fx_wa), .wdata(fx_wd), .raddr(fx_ra), .rdata(fx_rd));

  logic accept;
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Neighbor of the current flood/step cell on side_r.
  logic [3:0] cxf, cyf, nbx, nby;
  logic       nb_ok;
  logic [1:0] wcode;
  assign cxf   = cell_r[3:0];
  assign cyf   = cell_r[7:4];
  assign wcode = walls_r[side_r*2 +: 2];
  always_comb begin
    nbx = cxf;
    nby = cyf;
    nb_ok = 1'b0;
    case (side_r)
      2'd0: begin nby = cyf - 4'd1; nb_ok = (cyf != 4'd0);  end
      2'd1: begin nbx = cxf + 4'd1; nb_ok = (cxf != 4'd15); end
      2'd2: begin nby = cyf + 4'd1; nb_ok = (cyf != 4'd15); end
      default: begin nbx = cxf - 4'd1; nb_ok = (cxf != 4'd0); end
    endcase
  end
  logic pass_flood;
  assign pass_flood = (wcode == WOpen) || (unk_r && wcode == WUnknown);

  logic [2:0] present_cnt;
  always_comb begin
    present_cnt = '0;
    for (int s = 0; s < 4; s++) begin
      present_cnt = present_cnt + 3'((walls_r[s*2 +: 2] == WPresent) ? 1 : 0);
    end
  end

  // Step side order: east, south, west, north.
  function automatic logic [1:0] step_side(input logic [1:0] k);
    case (k)
      2'd0: return 2'd1;
      2'd1: return 2'd2;
      2'd2: return 2'd3;
      default: return 2'd0;
    endcase
  endfunction
  logic [1:0] stk_r, stk_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RESET_SWEEP;
      sweep_r <= '0;
      cnt_now_r <= '0;
      cnt_next_r <= '0;
      ovf_r <= 1'b0;
      copying_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      cnt_now_r <= cnt_now_nxt;
      cnt_next_r <= cnt_next_nxt;
      ovf_r <= ovf_nxt;
      copying_r <= copying_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind_t'(in_kind);
      cx_r <= in_cell_x;
      cy_r <= in_cell_y;
      tx_r <= in_target_x;
      ty_r <= in_target_y;
      unk_r <= in_unknown_open;
      wall_in_r <= {in_west_wall, in_south_wall, in_east_wall, in_north_wall};
    end
    pos_r <= pos_nxt;
    cell_r <= cell_nxt;
    walls_r <= walls_nxt;
    dist_r <= dist_nxt;
    len_r <= len_nxt;
    side_r <= side_nxt;
    status_r <= status_nxt;
    nx_r <= nx_nxt;
    ny_r <= ny_nxt;
    stk_r <= stk_nxt;
  end

  // Next-state and datapath sequencing.
  always_comb begin
    state_nxt = state_r;
    sweep_nxt = sweep_r;
    cnt_now_nxt = cnt_now_r;
    cnt_next_nxt = cnt_next_r;
    pos_nxt = pos_r;
    cell_nxt = cell_r;
    walls_nxt = walls_r;
    dist_nxt = dist_r;
    len_nxt = len_r;
    side_nxt = side_r;
    ovf_nxt = ovf_r;
    status_nxt = status_r;
    nx_nxt = nx_r;
    ny_nxt = ny_r;
    copying_nxt = copying_r;
    stk_nxt = stk_r;
    wall_we = 1'b0; wall_wa = cell_r; wall_wd = walls_r;
    dist_we = 1'b0; dist_wa = cell_r; dist_wd = dist_r;
    wall_ra = cell_r; dist_ra = cell_r;
    fn_we = 1'b0; fn_wa = pos_r[FrontW-1:0]; fn_wd = cell_r; fn_ra = pos_r[FrontW-1:0];
    fx_we = 1'b0; fx_wa = cnt_next_r[FrontW-1:0]; fx_wd = {nby, nbx};
    fx_ra = pos_r[FrontW-1:0];
    case (state_r)
      S_RESET_SWEEP: begin
        wall_we = 1'b1; wall_wa = sweep_r[CellW-1:0];
        wall_wd = reset_walls(sweep_r[CellW-1:0]);
        dist_we = 1'b1; dist_wa = sweep_r[CellW-1:0]; dist_wd = ResetDist;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == (CellW+1)'(Cells - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          nx_nxt = in_cell_x;
          ny_nxt = in_cell_y;
          status_nxt = ST_DONE;
          cell_nxt = {in_cell_y, in_cell_x};
          ovf_nxt = 1'b0;
          sweep_nxt = '0;
          case (kind_t'(in_kind))
            KIND_WALLS: state_nxt = S_OUT_RD;
            KIND_CLEAR: state_nxt = S_CLEAR;
            KIND_FLOOD: begin
              cell_nxt = {in_target_y, in_target_x};
              state_nxt = S_FL_INIT;
            end
            default: state_nxt = S_ST_RD;
          endcase
        end
      end
      S_CLEAR: begin
        dist_we = 1'b1; dist_wa = sweep_r[CellW-1:0]; dist_wd = Unreached;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == (CellW+1)'(Cells - 1)) begin
          state_nxt = S_OUT_RD;
        end
      end
      S_FL_INIT: begin
        dist_we = 1'b1; dist_wd = '0;
        fn_we = 1'b1; fn_wa = '0;
        cnt_now_nxt = (FrontW+1)'(1);
        cnt_next_nxt = '0;
        pos_nxt = '0;
        state_nxt = S_FL_POP;
      end
      S_FL_POP: begin
        if (pos_r == cnt_now_r) begin
          pos_nxt = '0;
          cnt_now_nxt = cnt_next_r;
          state_nxt = (cnt_next_r == '0) ? S_OUT_RD : S_FL_SWAP;
          copying_nxt = 1'b0;
        end else begin
          state_nxt = S_FL_POP_WAIT;
        end
      end
      S_FL_POP_WAIT: begin
        state_nxt = S_FL_CELL;
      end
      S_FL_CELL: begin
        cell_nxt = fn_rd;
        wall_ra = fn_rd;
        dist_ra = fn_rd;
        state_nxt = S_FL_GROW;
      end
      S_FL_GROW: begin
        // Registered reads of this cell are valid now.
        walls_nxt = wall_rd;
        dist_nxt = dist_rd;
        state_nxt = S_FL_NB_RD;
        side_nxt = 2'd0;
        copying_nxt = 1'b1;
      end
      S_FL_NB_RD: begin
        if (copying_r) begin
          // First pass: grow the cell by its present walls, store it.
          dist_nxt = sat_add(dist_r, 16'(present_cnt));
          dist_we = 1'b1;
          dist_wd = sat_add(dist_r, 16'(present_cnt));
          len_nxt = sat_add(sat_add(dist_r, 16'(present_cnt)), GrowStep);
          copying_nxt = 1'b0;
        end else if (pass_flood && nb_ok) begin
          dist_ra = {nby, nbx};
          state_nxt = S_FL_NB_WAIT;
        end else if (side_r == 2'd3) begin
          pos_nxt = pos_r + 1'b1;
          state_nxt = S_FL_POP;
        end else begin
          side_nxt = side_r + 2'd1;
        end
      end
      S_FL_NB_WAIT: begin
        // Hold the neighbor address so the compare sees its distance.
        dist_ra = {nby, nbx};
        state_nxt = S_FL_NB_CMP;
      end
      S_FL_NB_CMP: begin
        if (dist_rd > len_r) begin
          dist_we = 1'b1; dist_wa = {nby, nbx}; dist_wd = len_r;
          if (cnt_next_r < (FrontW+1)'(FrontierDepth)) begin
            fx_we = 1'b1;
            cnt_next_nxt = cnt_next_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        if (side_r == 2'd3) begin
          pos_nxt = pos_r + 1'b1;
          state_nxt = S_FL_POP;
        end else begin
          side_nxt = side_r + 2'd1;
          state_nxt = S_FL_NB_RD;
        end
      end
      S_FL_SWAP: begin
        // Copy the next wave into the current one, one entry a cycle;
        // read issued at pos_r, written back in the following cycle.
        fx_ra = pos_r[FrontW-1:0];
        if (copying_r) begin
          fn_we = 1'b1; fn_wa = pos_r[FrontW-1:0] - 1'b1; fn_wd = fx_rd;
        end
        copying_nxt = 1'b1;
        pos_nxt = pos_r + 1'b1;
        if (pos_r == cnt_now_r) begin
          pos_nxt = '0;
          cnt_next_nxt = '0;
          copying_nxt = 1'b0;
          state_nxt = S_FL_POP;
        end
      end
      S_ST_RD: begin
        if (cx_r == tx_r && cy_r == ty_r) begin
          status_nxt = ST_AT_TARGET;
          state_nxt = S_OUT_RD;
        end else begin
          state_nxt = S_ST_WAIT;
        end
      end
      S_ST_WAIT: begin
        state_nxt = S_ST_CUR;
      end
      S_ST_CUR: begin
        walls_nxt = wall_rd;
        dist_nxt = dist_rd;
        stk_nxt = 2'd0;
        side_nxt = step_side(2'd0);
        status_nxt = ST_NO_LOWER;
        state_nxt = S_ST_NB_WAIT;
        copying_nxt = 1'b0;
      end
      S_ST_NB_WAIT: begin
        // Issue the read for this side or skip it when blocked.
        if (wcode == WOpen && nb_ok) begin
          dist_ra = {nby, nbx};
          state_nxt = copying_r ? S_ST_NB_CMP : S_ST_NB_WAIT;
          copying_nxt = ~copying_r;
        end else if (stk_r == 2'd3) begin
          state_nxt = S_OUT_RD;
        end else begin
          stk_nxt = stk_r + 2'd1;
          side_nxt = step_side(stk_r + 2'd1);
        end
      end
      S_ST_NB_CMP: begin
        copying_nxt = 1'b0;
        if (dist_rd < dist_r) begin
          status_nxt = ST_MOVED;
          nx_nxt = nbx;
          ny_nxt = nby;
          state_nxt = S_OUT_RD;
        end else if (stk_r == 2'd3) begin
          state_nxt = S_OUT_RD;
        end else begin
          stk_nxt = stk_r + 2'd1;
          side_nxt = step_side(stk_r + 2'd1);
          state_nxt = S_ST_NB_WAIT;
        end
      end
      S_OUT_RD: begin
        if (kind_r == KIND_WALLS) begin
          wall_we = 1'b1; wall_wa = {cy_r, cx_r}; wall_wd = wall_in_r;
        end
        if (kind_r == KIND_FLOOD && ovf_r) begin
          status_nxt = ST_OVERFLOW;
        end
        dist_ra = {ny_r, nx_r};
        state_nxt = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        // Hold the result address through the registered read.
        dist_ra = {ny_r, nx_r};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_ST_RD) begin
      wall_ra = {cy_r, cx_r};
      dist_ra = {cy_r, cx_r};
    end
  end

  // Output drive.
  always_comb begin
    out_valid = (state_r == S_OUT);
    out_status = status_r;
    out_next_x = nx_r;
    out_next_y = ny_r;
    out_next_distance = dist_rd;
  end

`ifndef SYNTHESIS
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result shown while idle");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_next_r <= (FrontW+1)'(FrontierDepth)) else $error("frontier over depth");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("busy not raised after accept");
`endif
endmodule
